/* hdl/mbf_pkg.sv */
`default_nettype none
package mbf_pkg;
	localparam int MAX_BALLS = 64;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int DEN_W = 35;
	localparam int NUM_W = 47;
	localparam int ACC_W = 40;
	localparam logic [0:0] OP_LOAD = 1'b0;
	localparam logic [0:0] OP_EVAL = 1'b1;
	localparam logic [0:0] REG_BALL_COUNT = 1'b0;
	localparam logic [0:0] REG_ISO_LEVEL = 1'b1;

	typedef struct packed {
		logic start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;
endpackage
`default_nettype wire

/* hdl/metaball_field_evaluator.sv */
`default_nettype none
// Channel | Direction | Handshake
// request | in        | in_valid / in_ready
// result  | out       | out_valid / out_ready
// config  | in        | cfg_we, cfg_index, cfg_data
// A load writes the ball table and leaves the block idle. An evaluation keeps in_ready low
// over all its balls; each ball waits on the 47-step divider that all terms share.
// Reset clears control state; the ball table is not cleared.
// The result waits in an output register; a new request is taken meanwhile, and a
// following evaluation holds in its last state until that register is free.
module metaball_field_evaluator (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [0:0] operation,
	input  wire logic [5:0] ball_index,
	input  wire logic signed [15:0] point_x,
	input  wire logic signed [15:0] point_y,
	input  wire logic signed [15:0] point_z,
	input  wire logic signed [15:0] ball_power,
	output logic out_valid,
	input  wire logic out_ready,
	output logic signed [31:0] field_value,
	output logic inside_res,
	input  wire logic cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam logic [2:0] ST_IDLE = 3'd0, ST_READ = 3'd1, ST_SQ = 3'd2,
		ST_DIV = 3'd3, ST_WAIT = 3'd4, ST_ACC = 3'd5, ST_DONE = 3'd6, ST_FETCH = 3'd7;

	logic [2:0] state_q;
	logic [mbf_pkg::CNT_W-1:0] count_q, n_q, i_q;
	logic signed [31:0] iso_q;
	logic [63:0] mem [mbf_pkg::MAX_BALLS];
	logic [63:0] rd_q;
	logic signed [15:0] px_q, py_q, pz_q;
	logic signed [16:0] d_q [3];
	logic [33:0] sq_q [3];
	logic [31:0] mag2_q;
	logic neg_q;
	logic signed [mbf_pkg::ACC_W-1:0] acc_q;
	logic out_valid_q;
	logic signed [31:0] field_q;
	logic inside_q;
	mbf_pkg::div_req_t dreq;
	logic dbusy, ddone;
	logic [mbf_pkg::NUM_W-1:0] dquot;
	logic [15:0] pabs;
	logic [1:0] sq_step_q;
	logic signed [16:0] dsel;
	logic [16:0] dabs;
	logic [16:0] sq_in;
	logic [33:0] sq_out;
	logic signed [mbf_pkg::ACC_W-1:0] term;
	logic signed [31:0] field_sat;
	logic res_free;

	assign in_ready = (state_q == ST_IDLE);
	assign res_free = !out_valid_q || out_ready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			iso_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == mbf_pkg::REG_BALL_COUNT) count_q <= cfg_data[6:0];
			else iso_q <= cfg_data;
		end
	end

	// Ball table.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready && operation == mbf_pkg::OP_LOAD)
			mem[ball_index] <= {ball_power, point_z, point_y, point_x};
		rd_q <= mem[i_q[mbf_pkg::IDX_W-1:0]];
	end

	// One squarer shared over the three axes and the power.
	always_comb begin
		case (sq_step_q)
			2'd0: dsel = d_q[0];
			2'd1: dsel = d_q[1];
			2'd2: dsel = d_q[2];
			default: dsel = '0;
		endcase
	end
	assign dabs = dsel[16] ? 17'(-dsel) : 17'(dsel);
	assign pabs = rd_q[63] ? 16'(-rd_q[63:48]) : rd_q[63:48];
	assign sq_in = (sq_step_q == 2'd3) ? {1'b0, pabs} : dabs;
	assign sq_out = sq_in * sq_in;

	assign dreq.start = (state_q == ST_DIV);
	assign dreq.num = {mag2_q[30:0], 16'd0};
	assign dreq.den = 35'(sq_q[0]) + 35'(sq_q[1]) + 35'(sq_q[2]) + 35'd65536;
	assign term = neg_q ? -$signed({1'b0, dquot[38:0]}) : $signed({1'b0, dquot[38:0]});

	// The total saturates once to the 32-bit range.
	assign field_sat = (acc_q > 40'sd2147483647) ? 32'sh7fffffff :
		(acc_q < -40'sd2147483648) ? 32'sh80000000 : acc_q[31:0];

	mbf_divider u_div (.clk, .arst_n, .req(dreq), .busy(dbusy), .done(ddone),
		.quot(dquot));

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			i_q <= '0;
			n_q <= '0;
			sq_step_q <= '0;
		end else begin
			if (state_q == ST_DONE && res_free) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid && in_ready && operation == mbf_pkg::OP_EVAL) begin
					n_q <= (count_q > 7'(mbf_pkg::MAX_BALLS)) ?
						7'(mbf_pkg::MAX_BALLS) : count_q;
					i_q <= '0;
					state_q <= ST_FETCH;
				end
				ST_FETCH: state_q <= (i_q == n_q) ? ST_DONE : ST_READ;
				ST_READ: state_q <= ST_SQ;
				ST_SQ: begin
					sq_step_q <= sq_step_q + 2'd1;
					if (sq_step_q == 2'd3) begin
						sq_step_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: state_q <= ST_WAIT;
				ST_WAIT: if (ddone) state_q <= ST_ACC;
				ST_ACC: begin
					i_q <= i_q + 7'd1;
					state_q <= ST_FETCH;
				end
				ST_DONE: if (res_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_q <= point_x;
			py_q <= point_y;
			pz_q <= point_z;
			acc_q <= '0;
		end
		if (state_q == ST_READ) begin
			d_q[0] <= 17'(signed'(rd_q[15:0])) - 17'(px_q);
			d_q[1] <= 17'(signed'(rd_q[31:16])) - 17'(py_q);
			d_q[2] <= 17'(signed'(rd_q[47:32])) - 17'(pz_q);
			neg_q <= rd_q[63];
		end
		if (state_q == ST_SQ) begin
			if (sq_step_q == 2'd3) mag2_q <= sq_out[31:0];
			else sq_q[sq_step_q] <= sq_out;
		end
		if (state_q == ST_ACC) acc_q <= acc_q + term;
		if (state_q == ST_DONE && res_free) begin
			field_q <= field_sat;
			inside_q <= field_sat > iso_q;
		end
	end

	assign out_valid = out_valid_q;
	assign field_value = field_q;
	assign inside_res = inside_q;

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(field_value) && $stable(inside_res))
		else $error("result dropped or changed while waiting");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= 7'(mbf_pkg::MAX_BALLS)) else $error("ball count above table");
`endif
endmodule
`default_nettype wire

/* hdl/mbf_divider.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module mbf_divider (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire mbf_pkg::div_req_t req,
	output logic busy,
	output logic done,
	output logic [mbf_pkg::NUM_W-1:0] quot
);
	logic [mbf_pkg::NUM_W-1:0] q_q;
	logic [mbf_pkg::DEN_W:0] rem_q;
	logic [mbf_pkg::DEN_W-1:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q, done_q;
	logic [mbf_pkg::DEN_W+1:0] trial;

	assign trial = {rem_q, q_q[mbf_pkg::NUM_W-1]} - {2'b00, den_q};

	// Shift in one numerator bit and subtract when it fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(mbf_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[mbf_pkg::DEN_W+1]) begin
				rem_q <= trial[mbf_pkg::DEN_W:0];
				q_q <= {q_q[mbf_pkg::NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[mbf_pkg::DEN_W-1:0], q_q[mbf_pkg::NUM_W-1]};
				q_q <= {q_q[mbf_pkg::NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = q_q;

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without busy");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy) else $error("start while busy");
	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> cnt_q != 6'd0) else $error("busy with zero count");
`endif
endmodule
`default_nettype wire

/* test/metaball_field_evaluator_tb.sv */
`timescale 1ns / 100ps
module metaball_field_evaluator_tb;

	typedef struct {
		logic [0:0] op;
		logic [5:0] idx;
		logic signed [15:0] x, y, z, pw;
	} request_t;

	typedef struct {
		logic signed [31:0] field;
		logic above;
	} field_result_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [0:0] operation;
	logic [5:0] ball_index;
	logic signed [15:0] point_x, point_y, point_z, ball_power;
	logic signed [31:0] field_value;
	logic inside_res;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [31:0] cfg_data;

	request_t pending_reqs[$];
	field_result_t field_results[$];
	logic signed [15:0] tbl_x[mbf_pkg::MAX_BALLS], tbl_y[mbf_pkg::MAX_BALLS];
	logic signed [15:0] tbl_z[mbf_pkg::MAX_BALLS], tbl_pw[mbf_pkg::MAX_BALLS];
	logic [6:0] count_reg;
	logic signed [31:0] iso_reg;
	int faults;
	int req_gap, res_wait;
	bit calm;

	metaball_field_evaluator dut (.*);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Sum of inverse-square ball terms at a point, saturated to 32 bits.
	function automatic field_result_t sum_field(logic signed [15:0] px, py, pz);
		field_result_t r;
		longint acc, dx, dy, dz, den, mag, q;
		int n;
		acc = 0;
		n = (count_reg > mbf_pkg::MAX_BALLS) ? mbf_pkg::MAX_BALLS : count_reg;
		for (int i = 0; i < n; i++) begin
			dx = longint'(tbl_x[i]) - longint'(px);
			dy = longint'(tbl_y[i]) - longint'(py);
			dz = longint'(tbl_z[i]) - longint'(pz);
			den = dx * dx + dy * dy + dz * dz + 65536;
			mag = longint'(tbl_pw[i]);
			if (mag < 0)
				mag = -mag;
			q = ((mag * mag) << 16) / den;
			acc += (tbl_pw[i] < 0) ? -q : q;
		end
		if (acc > 64'sd2147483647)
			acc = 64'sd2147483647;
		if (acc < -64'sd2147483648)
			acc = -64'sd2147483648;
		r.field = acc[31:0];
		r.above = (acc > longint'(iso_reg));
		return r;
	endfunction

	// Request driver: takes accepted requests into the prediction, then presents the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (operation == mbf_pkg::OP_LOAD) begin
					tbl_x[ball_index] = point_x;
					tbl_y[ball_index] = point_y;
					tbl_z[ball_index] = point_z;
					tbl_pw[ball_index] = ball_power;
				end else begin
					field_results = {field_results, sum_field(point_x, point_y, point_z)};
				end
			end
			if (!in_valid || in_ready) begin
				if (req_gap > 0) begin
					req_gap <= req_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					request_t r;
					r = pending_reqs.pop_front();
					operation <= r.op;
					ball_index <= r.idx;
					point_x <= r.x;
					point_y <= r.y;
					point_z <= r.z;
					ball_power <= r.pw;
					in_valid <= 1'b1;
					req_gap <= calm ? 0 : $urandom_range(0, 7);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each result with the oldest prediction and stalls at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				int g;
				if (field_results.size() == 0) begin
					$error("result with no prediction waiting: field_value %0d", field_value);
					faults++;
				end else begin
					field_result_t e;
					e = field_results.pop_front();
					if (field_value !== e.field) begin
						$error("field_value: expected %0d, actual %0d", e.field, field_value);
						faults++;
					end
					if (inside_res !== e.above) begin
						$error("inside_res: expected %0d, actual %0d", e.above, inside_res);
						faults++;
					end
				end
				g = calm ? 0 : $urandom_range(0, 7);
				if (g != 0) begin
					out_ready <= 1'b0;
					res_wait <= g;
				end
			end else if (res_wait > 0) begin
				res_wait <= res_wait - 1;
				out_ready <= (res_wait == 1);
			end
		end
	end

	task automatic add_req(logic [0:0] op, logic [5:0] idx,
			logic signed [15:0] x, y, z, pw);
		request_t r;
		r.op = op;
		r.idx = idx;
		r.x = x;
		r.y = y;
		r.z = z;
		r.pw = pw;
		pending_reqs = {pending_reqs, r};
	endtask

	task automatic add_eval(logic signed [15:0] x, y, z);
		add_req(mbf_pkg::OP_EVAL, 6'($urandom), x, y, z, 16'($urandom));
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mbf_pkg::REG_BALL_COUNT)
			count_reg = val[6:0];
		else
			iso_reg = val;
	endtask

	// Waits until every request has gone in and every result has come out, then lets loads finish.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_reqs.size() > 0 || in_valid || field_results.size() > 0);
		repeat (16) @(posedge clk);
	endtask

	// Random evaluation point: anywhere, or close to a ball so that the terms are large.
	task automatic random_eval();
		int b;
		if ($urandom_range(0, 1)) begin
			add_eval(16'($urandom), 16'($urandom), 16'($urandom));
		end else begin
			b = $urandom_range(0, 7);
			add_eval(tbl_x[b] + $signed(16'($urandom_range(0, 512)) - 16'sd256),
				tbl_y[b] + $signed(16'($urandom_range(0, 512)) - 16'sd256),
				tbl_z[b] + $signed(16'($urandom_range(0, 512)) - 16'sd256));
		end
	endtask

	// Stimulus.
	initial begin
		int n_items, cnt;
		logic [31:0] iso;
		faults = 0;
		req_gap = 0;
		res_wait = 0;
		calm = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b1;
		operation = mbf_pkg::OP_LOAD;
		ball_index = '0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		ball_power = '0;
		cfg_we = 1'b0;
		cfg_index = mbf_pkg::REG_BALL_COUNT;
		cfg_data = '0;
		count_reg = '0;
		iso_reg = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no balls counted the field is zero, whatever the table holds.
		write_reg(mbf_pkg::REG_BALL_COUNT, 0);
		write_reg(mbf_pkg::REG_ISO_LEVEL, 0);
		add_eval(16'sh7fff, 16'sh8000, 16'sh0000);
		add_eval(16'sh8000, 16'sh7fff, 16'sh7fff);

		// Fill the table: strong positive balls together, strong negative balls together,
		// then the extremes of position and random entries.
		for (int i = 0; i < 3; i++)
			add_req(mbf_pkg::OP_LOAD, 6'(i), 16'sd0, 16'sd0, 16'sd0, 16'sh7fff);
		for (int i = 3; i < 7; i++)
			add_req(mbf_pkg::OP_LOAD, 6'(i), 16'sd1000, 16'sd1000, 16'sd1000, 16'sh8000);
		add_req(mbf_pkg::OP_LOAD, 6'd7, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh0000);
		add_req(mbf_pkg::OP_LOAD, 6'd8, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		for (int i = 9; i < mbf_pkg::MAX_BALLS; i++)
			add_req(mbf_pkg::OP_LOAD, 6'(i), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom));
		wait_idle();

		// Positive saturation at the positive cluster.
		write_reg(mbf_pkg::REG_BALL_COUNT, 3);
		write_reg(mbf_pkg::REG_ISO_LEVEL, 32'h7fffffff);
		add_eval(16'sd0, 16'sd0, 16'sd0);
		add_eval(16'sd1, 16'sd0, 16'sd0);
		wait_idle();

		// Negative saturation at the negative cluster, then points at the positive cluster and a corner.
		write_reg(mbf_pkg::REG_BALL_COUNT, 7);
		write_reg(mbf_pkg::REG_ISO_LEVEL, 32'h80000000);
		add_eval(16'sd1000, 16'sd1000, 16'sd1000);
		add_eval(16'sd0, 16'sd0, 16'sd0);
		add_eval(16'sh8000, 16'sh8000, 16'sh8000);
		wait_idle();

		// Full table, and a count above the table that saturates to it.
		write_reg(mbf_pkg::REG_BALL_COUNT, mbf_pkg::MAX_BALLS);
		write_reg(mbf_pkg::REG_ISO_LEVEL, 0);
		add_eval(16'sh7fff, 16'sh7fff, 16'sh7fff);
		add_eval(16'sd500, 16'sd500, 16'sd500);
		wait_idle();
		write_reg(mbf_pkg::REG_BALL_COUNT, 32'd127);
		add_eval(16'sh8000, 16'sh8000, 16'sh8000);
		add_eval(16'sd5, 16'sd5, 16'sd5);
		wait_idle();

		// Random phases, mostly with few balls counted so that evaluations stay short.
		for (int ph = 0; ph < 22; ph++) begin
			calm = ($urandom_range(0, 3) == 0);
			if (ph % 7 == 3) begin
				cnt = mbf_pkg::MAX_BALLS;
				n_items = 8;
			end else if (ph % 7 == 5) begin
				cnt = $urandom_range(mbf_pkg::MAX_BALLS + 1, 127);
				n_items = 6;
			end else begin
				cnt = $urandom_range(0, 8);
				n_items = 28;
			end
			case ($urandom_range(0, 4))
				0: iso = 32'h80000000;
				1: iso = 32'h7fffffff;
				2: iso = 0;
				3: iso = $urandom_range(0, 32'h00100000);
				default: iso = $urandom;
			endcase
			write_reg(mbf_pkg::REG_BALL_COUNT, cnt);
			write_reg(mbf_pkg::REG_ISO_LEVEL, iso);
			for (int k = 0; k < n_items; k++) begin
				if ($urandom_range(0, 2) == 0)
					add_req(mbf_pkg::OP_LOAD, 6'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom));
				else
					random_eval();
			end
			wait_idle();
		end
		calm = 1'b0;

		repeat (50) @(posedge clk);
		if (faults == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog.
	initial begin
		#200000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
